// File: rtl/core/sorted_sequence_merge_assert.svh
// Assertion macros shared by the sorted sequence merge design.
`ifndef SORTED_SEQUENCE_MERGE_ASSERT_SVH
`define SORTED_SEQUENCE_MERGE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SSM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ssm_pkg.sv
// Package with the command codes and state type of the sorted sequence merge.
package ssm_pkg;

    // Width of the value ports.
    localparam int VALUE_W = 32;

    // Width of the command field.
    localparam int KIND_W = 2;

    // Command codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_APPEND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MERGE         = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

// File: rtl/core/sorted_sequence_merge.sv
// Two-way merge of two sorted sequences held in two on-chip memories.
//
// Each append word is written into its memory at the fill count. A merge
// word first reads both heads from the memories into the read registers, then
// gives the stored values one per cycle while the output register can load,
// paced by the loop from the head compare to the next read address of the
// memories. No word is taken while a merge runs; a merge of two empty stores
// gives no result. Results leave through an output register, so a finished
// result may wait while the next word comes in. On equal heads the second
// sequence goes first. Appends to a full store are dropped and flagged on
// every result of the next merge.
module sorted_sequence_merge #(
    parameter int LIST_DEPTH  = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [ssm_pkg::KIND_W-1:0]   kind,
    input  logic signed [ssm_pkg::VALUE_W-1:0] value,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [ssm_pkg::VALUE_W-1:0] merged_value,
    output logic                         last,
    output logic                         overflow
);

`include "sorted_sequence_merge_assert.svh"

    localparam int PW      = ssm_pkg::VALUE_W;
    localparam int STORE_W = (VALUE_WIDTH < PW) ? VALUE_WIDTH : PW;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int REM_W   = $clog2(2 * LIST_DEPTH + 1);

    // Sequencer and bookkeeping registers.
    ssm_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   first_count_reg, first_count_next;
    logic [CNT_W-1:0]   second_count_reg, second_count_next;
    logic               dropped_reg, dropped_next;
    logic [CNT_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]   b_reg, b_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    // Output register.
    logic               result_valid_reg, result_valid_next;
    logic [PW-1:0]      merged_value_reg, merged_value_next;
    logic               last_reg, last_next;
    logic               overflow_reg, overflow_next;

    // Memories and their registered read data.
    logic [STORE_W-1:0] first_mem [LIST_DEPTH];
    logic [STORE_W-1:0] second_mem [LIST_DEPTH];
    logic [STORE_W-1:0] rd_first_reg;
    logic [STORE_W-1:0] rd_second_reg;

    logic               item_accept;
    logic               out_load;
    logic               emit;
    logic               first_avail;
    logic               second_avail;
    logic               take_first;
    logic               first_full;
    logic               second_full;
    logic               wr_first;
    logic               wr_second;
    logic [STORE_W-1:0] key;
    logic [STORE_W-1:0] sel_value;
    logic [REM_W-1:0]   total;

    // Handshake and write decode.
    assign item_ready  = (state_reg == ssm_pkg::ST_IDLE);
    assign item_accept = item_valid && item_ready;
    assign out_load    = !result_valid_reg || result_ready;
    assign emit        = (state_reg == ssm_pkg::ST_MERGE) && out_load;
    assign first_full  = (first_count_reg >= CNT_W'(LIST_DEPTH));
    assign second_full = (second_count_reg >= CNT_W'(LIST_DEPTH));
    assign wr_first    = item_accept && (kind == ssm_pkg::KIND_APPEND_FIRST) && !first_full;
    assign wr_second   = item_accept && (kind == ssm_pkg::KIND_APPEND_SECOND) && !second_full;
    assign key         = value[STORE_W-1:0];
    assign total       = REM_W'(first_count_reg) + REM_W'(second_count_reg);

    // Head compare; a strict less-than lets the second sequence win a tie.
    assign first_avail  = (a_reg < first_count_reg);
    assign second_avail = (b_reg < second_count_reg);
    assign take_first   = first_avail &&
                          (!second_avail || ($signed(rd_first_reg) < $signed(rd_second_reg)));
    assign sel_value    = take_first ? rd_first_reg : rd_second_reg;

    // Next state of the sequencer, counts and read pointers.
    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        rem_next          = rem_reg;
        case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (kind)
                        ssm_pkg::KIND_APPEND_FIRST:
                        begin
                            if (first_full)
                                dropped_next = 1'b1;
                            else
                                first_count_next = first_count_reg + CNT_W'(1);
                        end
                        ssm_pkg::KIND_APPEND_SECOND:
                        begin
                            if (second_full)
                                dropped_next = 1'b1;
                            else
                                second_count_next = second_count_reg + CNT_W'(1);
                        end
                        ssm_pkg::KIND_MERGE:
                        begin
                            if (total == '0)
                                dropped_next = 1'b0;
                            else
                            begin
                                state_next = ssm_pkg::ST_MERGE;
                                rem_next   = total;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ssm_pkg::ST_MERGE:
            begin
                if (emit)
                begin
                    if (take_first)
                        a_next = a_reg + CNT_W'(1);
                    else
                        b_next = b_reg + CNT_W'(1);
                    rem_next = rem_reg - REM_W'(1);
                    // The final word empties both stores and clears the drop flag.
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next        = ssm_pkg::ST_IDLE;
                        a_next            = '0;
                        b_next            = '0;
                        first_count_next  = '0;
                        second_count_next = '0;
                        dropped_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ssm_pkg::ST_IDLE;
                a_next     = '0;
                b_next     = '0;
            end
        endcase
    end

    // Next value of the output register.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        merged_value_next = merged_value_reg;
        last_next         = last_reg;
        overflow_next     = overflow_reg;
        if (out_load)
        begin
            result_valid_next = emit;
            if (emit)
            begin
                merged_value_next = PW'($signed(sel_value));
                last_next         = (rem_reg == REM_W'(1));
                overflow_next     = dropped_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ssm_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            a_reg            <= '0;
            b_reg            <= '0;
            rem_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            rem_reg          <= rem_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        merged_value_reg <= merged_value_next;
        last_reg         <= last_next;
        overflow_reg     <= overflow_next;
    end

    // First memory: written at the fill count, read at the next head pointer.
    always_ff @(posedge clk)
    begin
        if (wr_first)
            first_mem[first_count_reg[IDX_W-1:0]] <= key;
        rd_first_reg <= first_mem[a_next[IDX_W-1:0]];
    end

    // Second memory: written at the fill count, read at the next head pointer.
    always_ff @(posedge clk)
    begin
        if (wr_second)
            second_mem[second_count_reg[IDX_W-1:0]] <= key;
        rd_second_reg <= second_mem[b_next[IDX_W-1:0]];
    end

    assign result_valid = result_valid_reg;
    assign merged_value = merged_value_reg;
    assign last         = last_reg;
    assign overflow     = overflow_reg;

    // Head pointers never pass the fill counts.
    `SSM_ASSERT_SAME(a_ptr_bound, state_reg == ssm_pkg::ST_MERGE, (a_reg <= first_count_reg) && (b_reg <= second_count_reg), "head pointer beyond fill count")
    // The remaining count matches what is left in both stores.
    `SSM_ASSERT_SAME(a_rem_match, state_reg == ssm_pkg::ST_MERGE, rem_reg == (REM_W'(first_count_reg - a_reg) + REM_W'(second_count_reg - b_reg)), "remaining count out of step with pointers")
    // After the final word both stores are empty and the sequencer is idle.
    `SSM_ASSERT_NEXT(a_merge_done, emit && (rem_reg == REM_W'(1)), (state_reg == ssm_pkg::ST_IDLE) && (first_count_reg == '0) && (second_count_reg == '0) && !dropped_reg, "stores not emptied after merge")
    // Fill counts stay within the store depth.
    `SSM_ASSERT_SAME(a_count_bound, item_valid || !item_valid, (first_count_reg <= CNT_W'(LIST_DEPTH)) && (second_count_reg <= CNT_W'(LIST_DEPTH)), "fill count beyond depth")

endmodule
